/* hw/rtl/mmi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mmi_pkg;

  // modulus and result width
  localparam int MOD_BITS  = 31;
  // datapath width: one bit of headroom over the modulus
  localparam int DW        = MOD_BITS + 1;
  localparam int WIDTH_DEF = 32;
  // iteration counter, phase one runs at most 2 * MOD_BITS passes
  localparam int KW        = $clog2(2 * MOD_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_LOOP,
    ST_FOLD,
    ST_SUBP,
    ST_HALVE,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_fire;
    logic p_even;
    logic div_last;
    logic v_zero;
    logic u_one;
    logic k_zero;
    logic out_busy;
  } status_t;

  typedef struct packed {
    state_t step;
    logic   in_ready;
    logic   out_load;
  } ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/mmi_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mmi_in_if #(
  parameter int WIDTH = mmi_pkg::WIDTH_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic signed [WIDTH-1:0]  operand_a;

  modport source (output valid, output operand_a, input ready);
  modport sink (input valid, input operand_a, output ready);
endinterface

interface mmi_out_if ();
  logic                         valid;
  logic                         ready;
  logic [mmi_pkg::MOD_BITS-1:0] inverse;
  logic                         not_invertible;

  modport source (output valid, output inverse, output not_invertible, input ready);
  modport sink (input valid, input inverse, input not_invertible, output ready);
endinterface

interface mmi_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [mmi_pkg::MOD_BITS-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mmi_addsub.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmi_addsub (
  input  wire logic [mmi_pkg::DW-1:0] a,
  input  wire logic [mmi_pkg::DW-1:0] b,
  output logic      [mmi_pkg::DW:0]   sum,
  output logic      [mmi_pkg::DW-1:0] dab,
  output logic      [mmi_pkg::DW-1:0] dba,
  output logic                        ge,
  output logic                        gt
);

  logic [mmi_pkg::DW:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};
  assign dab  = diff[mmi_pkg::DW-1:0];
  assign dba  = b - a;
  // no borrow means a >= b
  assign ge   = ~diff[mmi_pkg::DW];
  assign gt   = ~diff[mmi_pkg::DW] && (a != b);

endmodule

`default_nettype wire

/* hw/rtl/mmi_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmi_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mmi_pkg::status_t status,
  output mmi_pkg::ctrl_t        ctrl
);

  mmi_pkg::state_t state_r;
  mmi_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmi_pkg::ST_IDLE: begin
        if (status.in_fire) begin
          state_nxt = status.p_even ? mmi_pkg::ST_DONE : mmi_pkg::ST_DIV;
        end
      end
      mmi_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = mmi_pkg::ST_FIX;
        end
      end
      mmi_pkg::ST_FIX:  state_nxt = mmi_pkg::ST_LOOP;
      mmi_pkg::ST_LOOP: begin
        if (status.v_zero) begin
          state_nxt = status.u_one ? mmi_pkg::ST_FOLD : mmi_pkg::ST_DONE;
        end
      end
      mmi_pkg::ST_FOLD: state_nxt = mmi_pkg::ST_SUBP;
      mmi_pkg::ST_SUBP: state_nxt = mmi_pkg::ST_HALVE;
      mmi_pkg::ST_HALVE: begin
        if (status.k_zero) begin
          state_nxt = mmi_pkg::ST_FINAL;
        end
      end
      mmi_pkg::ST_FINAL: state_nxt = mmi_pkg::ST_DONE;
      mmi_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          state_nxt = mmi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.step     = state_r;
    ctrl.in_ready = 1'b0;
    ctrl.out_load = 1'b0;
    case (state_r)
      mmi_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      mmi_pkg::ST_DONE: ctrl.out_load = ~status.out_busy;
      default: begin
        ctrl.in_ready = 1'b0;
        ctrl.out_load = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/montgomery_modular_inverse_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// sequence: the operand is reduced modulo p msb first, then sign-fixed; phase one runs
//   k <= 62 passes, then come a fold, a subtraction of p, k halvings modulo p and a
//   final reduction; a gcd other than one ends after phase one, an even or zero
//   modulus goes straight to the result. One transaction at a time, the next taken
//   in idle once the result is loaded; one shared add/sub unit serves all the steps
// reset: rst_n synchronous active low, returns the sequencer to idle, drops out valid
//   and sets the modulus to 1
module montgomery_modular_inverse_core #(
  parameter int WIDTH = mmi_pkg::WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mmi_in_if.sink     in_chan,
  mmi_out_if.source  out_chan,
  mmi_cfg_if.sink    cfg_chan
);

  localparam int MB = mmi_pkg::MOD_BITS;
  localparam int DW = mmi_pkg::DW;
  localparam int KW = mmi_pkg::KW;
  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // modulus register, to be written only while idle with nothing in flight
  logic [MB-1:0] modulus_r;

  // iteration state
  logic [WIDTH-1:0] div_r,  div_nxt;     // operand magnitude, shifted out msb first
  logic [CW-1:0]    cnt_r,  cnt_nxt;     // reduction bits left after the current one
  logic             neg_r,  neg_nxt;
  logic [MB-1:0]    u_r,    u_nxt;
  logic [MB-1:0]    v_r,    v_nxt;       // also the running remainder of the reduction
  logic [DW-1:0]    r_r,    r_nxt;
  logic [DW-1:0]    s_r,    s_nxt;
  logic [DW-1:0]    res_r,  res_nxt;
  logic [KW-1:0]    k_r,    k_nxt;
  logic             fail_r, fail_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [MB-1:0] out_inv_r,   out_inv_nxt;
  logic          out_ni_r,    out_ni_nxt;

  // shared unit
  logic [DW-1:0] ua, ub;
  logic [DW:0]   u_sum;
  logic [DW-1:0] u_dab, u_dba;
  logic          u_ge, u_gt;

  logic [DW-1:0]    rs_sum;
  logic [WIDTH-1:0] opnd;
  logic [WIDTH-1:0] mag;

  mmi_pkg::status_t status;
  mmi_pkg::ctrl_t   ctrl;

  mmi_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mmi_addsub u_addsub (
    .a   (ua),
    .b   (ub),
    .sum (u_sum),
    .dab (u_dab),
    .dba (u_dba),
    .ge  (u_ge),
    .gt  (u_gt)
  );

  // handshakes
  assign in_chan.ready   = ctrl.in_ready;
  assign cfg_chan.ready  = 1'b1;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.inverse        = out_inv_r;
  assign out_chan.not_invertible = out_ni_r;

  assign status.in_fire  = in_chan.valid && ctrl.in_ready;
  assign status.p_even   = ~modulus_r[0];
  assign status.div_last = (cnt_r == '0);
  assign status.v_zero   = (v_r == '0);
  assign status.u_one    = (u_r == MB'(1));
  assign status.k_zero   = (k_r == '0);
  assign status.out_busy = out_valid_r && !out_chan.ready;

  // magnitude of the two's complement operand
  assign opnd = $unsigned(in_chan.operand_a);
  assign mag  = opnd[WIDTH-1] ? (~opnd + 1'b1) : opnd;

  assign rs_sum = r_r + s_r;

  // operand select of the shared unit
  always_comb begin
    ua = '0;
    ub = '0;
    case (ctrl.step)
      mmi_pkg::ST_DIV: begin
        ua = {v_r, div_r[WIDTH-1]};
        ub = {1'b0, modulus_r};
      end
      mmi_pkg::ST_FIX: begin
        ua = {1'b0, modulus_r};
        ub = {1'b0, v_r};
      end
      mmi_pkg::ST_LOOP: begin
        ua = {1'b0, u_r};
        ub = {1'b0, v_r};
      end
      mmi_pkg::ST_FOLD: begin
        ua = r_r;
        ub = {1'b0, modulus_r};
      end
      mmi_pkg::ST_SUBP: begin
        ua = {1'b0, modulus_r};
        ub = r_r;
      end
      mmi_pkg::ST_HALVE, mmi_pkg::ST_FINAL: begin
        ua = res_r;
        ub = {1'b0, modulus_r};
      end
      default: begin
        ua = '0;
        ub = '0;
      end
    endcase
  end

  // datapath next state
  always_comb begin
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    s_nxt    = s_r;
    res_nxt  = res_r;
    k_nxt    = k_r;
    fail_nxt = fail_r;
    case (ctrl.step)
      mmi_pkg::ST_IDLE: begin
        if (status.in_fire) begin
          div_nxt  = mag;
          cnt_nxt  = CW'(WIDTH - 1);
          neg_nxt  = opnd[WIDTH-1];
          u_nxt    = modulus_r;
          v_nxt    = '0;
          r_nxt    = '0;
          s_nxt    = DW'(1);
          k_nxt    = '0;
          fail_nxt = status.p_even;
        end
      end
      mmi_pkg::ST_DIV: begin
        // restoring division step, remainder stays below p
        v_nxt   = u_ge ? u_dab[MB-1:0] : ua[MB-1:0];
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      mmi_pkg::ST_FIX: begin
        // negative operand with nonzero remainder maps to p - rem
        if (neg_r && !status.v_zero) begin
          v_nxt = u_dab[MB-1:0];
        end
      end
      mmi_pkg::ST_LOOP: begin
        if (!status.v_zero) begin
          k_nxt = k_r + 1'b1;
          if (!u_r[0]) begin
            u_nxt = u_r >> 1;
            s_nxt = s_r << 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
            r_nxt = r_r << 1;
          end else if (u_gt) begin
            u_nxt = u_dab[MB:1];
            r_nxt = rs_sum;
            s_nxt = s_r << 1;
          end else begin
            v_nxt = u_dba[MB:1];
            s_nxt = rs_sum;
            r_nxt = r_r << 1;
          end
        end else if (!status.u_one) begin
          // gcd not one
          fail_nxt = 1'b1;
        end
      end
      mmi_pkg::ST_FOLD: begin
        if (u_ge) begin
          r_nxt = u_dab;
        end
      end
      mmi_pkg::ST_SUBP: begin
        res_nxt = u_dab;
      end
      mmi_pkg::ST_HALVE: begin
        // halve modulo p, odd values take p first
        if (!status.k_zero) begin
          res_nxt = res_r[0] ? u_sum[DW:1] : (res_r >> 1);
          k_nxt   = k_r - 1'b1;
        end
      end
      mmi_pkg::ST_FINAL: begin
        if (u_ge) begin
          res_nxt = u_dab;
        end
      end
      default: begin
        fail_nxt = fail_r;
      end
    endcase
  end

  // result register, takes a new result once the last one is gone
  always_comb begin
    out_inv_nxt   = out_inv_r;
    out_ni_nxt    = out_ni_r;
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_inv_nxt   = fail_r ? '0 : res_r[MB-1:0];
      out_ni_nxt    = fail_r;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MB'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        modulus_r <= cfg_chan.modulus;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    r_r       <= r_nxt;
    s_r       <= s_nxt;
    res_r     <= res_nxt;
    k_r       <= k_nxt;
    fail_r    <= fail_nxt;
    out_inv_r <= out_inv_nxt;
    out_ni_r  <= out_ni_nxt;
  end

  // reduction remainder stays below the modulus
  a_rem_below_p: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step == mmi_pkg::ST_FIX) |-> (v_r < modulus_r))
    else $error("remainder not below modulus");

  // u never grows past the modulus in phase one
  a_u_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step == mmi_pkg::ST_LOOP) |-> (u_r <= modulus_r))
    else $error("u above modulus");

  // pass counter never wraps during phase one
  a_k_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step == mmi_pkg::ST_LOOP && !status.v_zero) |=> (k_r != '0))
    else $error("pass counter wrapped");

  // a good result lies in 0..p-1
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ni_r) |-> (out_inv_r < modulus_r))
    else $error("inverse out of range");

  // a failed transaction reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ni_r) |-> (out_inv_r == '0))
    else $error("nonzero inverse with not_invertible");

endmodule

`default_nettype wire
